// ----- hdl/mlbp_pkg.sv -----
`timescale 1ns / 1ps

package mlbp_pkg;

  localparam int LED_TOTAL_DEFAULT = 8;

  localparam int FREQ_W   = 16;
  localparam int COUNT_W  = 4;
  localparam int INDEX_W  = 8;
  localparam int TIME_W   = 32;
  localparam int DUTY_W   = 7;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_FREQUENCY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT       = 1'd1;

  localparam logic [FREQ_W-1:0]  FREQ_RESET  = 16'd1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  localparam logic [DUTY_W-1:0] DUTY_STEP = 7'd10;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;

  // dividends are at most 1270, padded to an even bit count
  localparam int DIV_W = 12;
  localparam logic [DIV_W-1:0] PERIOD_SCALE = 12'd1000;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES = DIV_W / DIV_BITS_PER_CYCLE;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              up;
    logic [TIME_W-1:0] last;
    logic              lit;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{duty: '0, up: 1'b1, last: '0, lit: 1'b0};

  typedef struct packed {
    logic [FREQ_W-1:0] rem;
    logic [DIV_W-1:0]  quo;
  } div_t;

  // one restoring division step; quo shifts the dividend out and the quotient in
  function automatic div_t div_step(div_t d, logic [FREQ_W-1:0] divisor);
    div_t            r;
    logic [FREQ_W:0] trial;
    trial = {d.rem, d.quo[DIV_W-1]};
    r.quo = {d.quo[DIV_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
      r.quo[0] = 1'b1;
    end
    r.rem = trial[FREQ_W-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/multi_led_breathing_pwm_top.sv -----
`timescale 1ns / 1ps
// Multi-LED breathing PWM.
// Input channel (in_valid / in_stall): led_index and time_ms. Each request
// steps one LED's software PWM and gives exactly one result on the output
// channel (out_valid / out_stall): led_number, accepted, led_lit,
// level_changed and duty_percent.
// Per-LED state (duty, sweep direction, last edge time, lit) sits in a
// single-port table with a registered read; a request reads its entry,
// runs the on/off period divisions, then writes the entry back.
// An in-range request goes from accept to out_valid through the table read,
// the shared 2-bit-per-cycle divider, the write-back and the output register;
// a request rejected at accept goes straight to the output register.
// One request is in flight at a time; a new one is taken once the last has
// reached the output register; in_stall is high while a request is worked.
// When the receiver stalls, the result holds in the output register and the
// next request is accepted but completes only once that register is free.
// Reset: synchronous; every LED starts dark, duty 0, sweeping upward, and
// blink_frequency is 1, led_count 8. Users write registers via cfg_write /
// cfg_index / cfg_data only while no request is in flight; unchecked here.
module multi_led_breathing_pwm_top #(
  parameter int LED_TOTAL = mlbp_pkg::LED_TOTAL_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mlbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlbp_pkg::FREQ_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mlbp_pkg::INDEX_W-1:0]    led_index,
  input  logic [mlbp_pkg::TIME_W-1:0]     time_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mlbp_pkg::INDEX_W-1:0]    led_number,
  output logic                            accepted,
  output logic                            led_lit,
  output logic                            level_changed,
  output logic [mlbp_pkg::DUTY_W-1:0]     duty_percent
);

  localparam int IW = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
  localparam int TW = mlbp_pkg::TIME_W;
  localparam int DW = mlbp_pkg::DIV_W;
  localparam int CW = $clog2(mlbp_pkg::DIV_CYCLES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;

  logic [mlbp_pkg::FREQ_W-1:0]  blink_frequency;
  logic [mlbp_pkg::COUNT_W-1:0] led_count;

  mlbp_pkg::entry_t entry_mem [LED_TOTAL];
  mlbp_pkg::entry_t rd_data;
  logic [LED_TOTAL-1:0] entry_valid;
  logic                mem_we;
  mlbp_pkg::entry_t    wr_data;

  logic [mlbp_pkg::INDEX_W-1:0] cur_index;
  logic [TW-1:0]                cur_time;
  mlbp_pkg::entry_t             ent;
  mlbp_pkg::entry_t             ent_read;

  mlbp_pkg::div_t on_div, on_div_next;
  mlbp_pkg::div_t per_div, per_div_next;
  logic [CW-1:0]  div_cnt;

  logic                         res_accepted;
  logic                         res_lit;
  logic                         res_changed;
  logic [mlbp_pkg::DUTY_W-1:0]  res_duty;

  logic in_accept;
  logic in_range;

  logic [TW-1:0]  elapsed;
  logic [DW-1:0]  off_ms;
  logic           light;
  logic           lit_mid;
  logic           dark;
  logic           up_new;
  logic [DW+1:0]  on_dividend;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_range  = ({1'b0, led_index} < 9'(LED_TOTAL)) &&
                     ({4'b0, led_index[mlbp_pkg::INDEX_W-1:0]} <
                      {8'b0, led_count}) &&
                     (blink_frequency != '0);

  // table entry never written reads as the reset state
  assign ent_read = entry_valid[cur_index[IW-1:0]] ? rd_data : mlbp_pkg::ENTRY_RESET;

  // duty * 10 as shifts
  assign on_dividend = ({7'b0, ent_read.duty} << 3) + ({7'b0, ent_read.duty} << 1);

  always_comb begin
    on_div_next  = on_div;
    per_div_next = per_div;
    for (int i = 0; i < mlbp_pkg::DIV_BITS_PER_CYCLE; i++) begin
      on_div_next  = mlbp_pkg::div_step(on_div_next, blink_frequency);
      per_div_next = mlbp_pkg::div_step(per_div_next, blink_frequency);
    end
  end

  // both edge checks of one step
  always_comb begin
    elapsed = cur_time - ent.last;
    off_ms  = per_div.quo - on_div.quo;
    light   = !ent.lit && (elapsed >= {{(TW-DW){1'b0}}, off_ms});
    lit_mid = ent.lit || light;
    // after lighting in this step the elapsed time restarts at zero
    dark    = lit_mid && (light ? (on_div.quo == '0)
                                : (elapsed >= {{(TW-DW){1'b0}}, on_div.quo}));
    if (ent.duty == mlbp_pkg::DUTY_MAX) begin
      up_new = 1'b0;
    end else if (ent.duty == '0) begin
      up_new = 1'b1;
    end else begin
      up_new = ent.up;
    end
    wr_data.lit  = lit_mid && !dark;
    wr_data.last = (light || dark) ? cur_time : ent.last;
    wr_data.up   = dark ? up_new : ent.up;
    if (!dark) begin
      wr_data.duty = ent.duty;
    end else if (up_new) begin
      wr_data.duty = ent.duty + mlbp_pkg::DUTY_STEP;
    end else begin
      wr_data.duty = ent.duty - mlbp_pkg::DUTY_STEP;
    end
    mem_we = (state == ST_EVAL);
  end

  // state table: registered read, write-back at the end of a request
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[cur_index[IW-1:0]] <= wr_data;
    end
    if (in_accept && in_range) begin
      rd_data <= entry_mem[led_index[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      blink_frequency <= mlbp_pkg::FREQ_RESET;
      led_count       <= mlbp_pkg::COUNT_RESET;
      entry_valid     <= '0;
      out_valid       <= 1'b0;
      div_cnt         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mlbp_pkg::REG_BLINK_FREQUENCY: blink_frequency <= cfg_data;
          mlbp_pkg::REG_LED_COUNT:       led_count <= cfg_data[mlbp_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      // in ST_OUT the output register is reloaded below
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            cur_index <= led_index;
            cur_time  <= time_ms;
            if (in_range) begin
              state <= ST_READ;
            end else begin
              res_accepted <= 1'b0;
              res_lit      <= 1'b0;
              res_changed  <= 1'b0;
              res_duty     <= '0;
              state        <= ST_OUT;
            end
          end
        end
        ST_READ: begin
          ent          <= ent_read;
          on_div.rem   <= '0;
          on_div.quo   <= on_dividend[DW-1:0];
          per_div.rem  <= '0;
          per_div.quo  <= mlbp_pkg::PERIOD_SCALE;
          div_cnt      <= '0;
          if (ent_read.duty > mlbp_pkg::DUTY_MAX) begin
            res_accepted <= 1'b0;
            res_lit      <= 1'b0;
            res_changed  <= 1'b0;
            res_duty     <= '0;
            state        <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          on_div  <= on_div_next;
          per_div <= per_div_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CW'(mlbp_pkg::DIV_CYCLES - 1)) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          entry_valid[cur_index[IW-1:0]] <= 1'b1;
          res_accepted <= 1'b1;
          res_lit      <= wr_data.lit;
          res_changed  <= (wr_data.lit != ent.lit);
          res_duty     <= wr_data.duty;
          state        <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            led_number    <= cur_index;
            accepted      <= res_accepted;
            led_lit       <= res_lit;
            level_changed <= res_changed;
            duty_percent  <= res_duty;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mlbp_pkg::*;

  localparam int LED_SLOTS = LED_TOTAL_DEFAULT;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 13;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [INDEX_W-1:0] led_number;
    logic               accepted;
    logic               led_lit;
    logic               level_changed;
    logic [DUTY_W-1:0]  duty_percent;
  } pwm_result_t;

  typedef enum bit {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [FREQ_W-1:0]    reg_val;
    logic [INDEX_W-1:0]   led;
    logic [TIME_W-1:0]    now;
    bit                   typed;
    pwm_result_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FREQ_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [INDEX_W-1:0] led_index = '0;
  logic [TIME_W-1:0] time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [INDEX_W-1:0] led_number;
  logic accepted;
  logic led_lit;
  logic level_changed;
  logic [DUTY_W-1:0] duty_percent;

  // per-LED breathing state as the block should hold it
  logic [DUTY_W-1:0] led_duty [LED_SLOTS];
  logic              led_rising [LED_SLOTS];
  logic [TIME_W-1:0] led_edge_ms [LED_SLOTS];
  logic              led_on [LED_SLOTS];
  logic [FREQ_W-1:0] freq_div;
  logic [COUNT_W-1:0] leds_enabled;

  pwm_result_t result_queue [$];
  stim_row_t directed_rows [$];
  int error_count = 0;
  int requests_sent = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet;
  logic [TIME_W-1:0] clock_ms;

  int phase_freq [PHASES] = '{1, 0, 65535, 1000, 500, 10, 4, 1, 200, 2, 100, 1, 33};
  int phase_count [PHASES] = '{8, 8, 15, 8, 8, 8, 3, 0, 1, 8, 9, 8, 8};

  // no idling on either side for a stretch of requests
  assign quiet = (requests_sent >= 700) && (requests_sent < 1000);

  multi_led_breathing_pwm_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .led_index(led_index),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .led_number(led_number),
    .accepted(accepted),
    .led_lit(led_lit),
    .level_changed(level_changed),
    .duty_percent(duty_percent)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pwm_result_t predict_led_step(logic [INDEX_W-1:0] idx,
                                                   logic [TIME_W-1:0] now);
    pwm_result_t r;
    logic [TIME_W-1:0] on_ms;
    logic [TIME_W-1:0] off_ms;
    logic [TIME_W-1:0] since;
    logic was_on;
    r = '0;
    r.led_number = idx;
    if (idx >= LED_SLOTS || idx >= leds_enabled || freq_div == '0) return r;
    if (led_duty[idx] > DUTY_MAX) return r;
    on_ms = (TIME_W'(led_duty[idx]) * 32'd10) / TIME_W'(freq_div);
    off_ms = TIME_W'(PERIOD_SCALE) / TIME_W'(freq_div) - on_ms;
    was_on = led_on[idx];
    since = now - led_edge_ms[idx];
    if (!led_on[idx] && since >= off_ms) begin
      led_on[idx] = 1'b1;
      led_edge_ms[idx] = now;
    end
    since = now - led_edge_ms[idx];
    if (led_on[idx] && since >= on_ms) begin
      led_on[idx] = 1'b0;
      led_edge_ms[idx] = now;
      if (led_duty[idx] == DUTY_MAX) led_rising[idx] = 1'b0;
      if (led_duty[idx] == '0) led_rising[idx] = 1'b1;
      if (led_rising[idx]) led_duty[idx] = led_duty[idx] + DUTY_STEP;
      else led_duty[idx] = led_duty[idx] - DUTY_STEP;
    end
    r.accepted = 1'b1;
    r.led_lit = led_on[idx];
    r.level_changed = led_on[idx] != was_on;
    r.duty_percent = led_duty[idx];
    return r;
  endfunction

  function automatic stim_row_t request_row(logic [INDEX_W-1:0] led, logic [TIME_W-1:0] now,
                                            bit typed = 1'b0, pwm_result_t want = '0);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.led = led;
    row.now = now;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t register_row(logic [CFG_IDX_W-1:0] sel, logic [FREQ_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REGISTER;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic pwm_result_t rejected(logic [INDEX_W-1:0] led);
    pwm_result_t r;
    r = '0;
    r.led_number = led;
    return r;
  endfunction

  task automatic send_request(input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] now,
                              input bit typed, input pwm_result_t want);
    pwm_result_t predicted;
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    led_index <= idx;
    time_ms <= now;
    do @(posedge clk); while (in_stall);
    predicted = predict_led_step(idx, now);
    result_queue.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [FREQ_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (sel == REG_BLINK_FREQUENCY) freq_div = val;
    else leds_enabled = val[COUNT_W-1:0];
  endtask

  initial begin
    int live;
    int span;
    logic [INDEX_W-1:0] idx;
    for (int i = 0; i < LED_SLOTS; i++) begin
      led_duty[i] = '0;
      led_rising[i] = 1'b1;
      led_edge_ms[i] = '0;
      led_on[i] = 1'b0;
    end
    freq_div = FREQ_RESET;
    leds_enabled = COUNT_RESET;

    directed_rows.push_back(request_row(8'd0, 32'd0, 1'b1,
      '{led_number: 8'd0, accepted: 1'b1, led_lit: 1'b0, level_changed: 1'b0,
        duty_percent: 7'd0}));
    // zero on time: lights and darkens in one request
    directed_rows.push_back(request_row(8'd0, 32'd1000));
    directed_rows.push_back(request_row(8'd0, 32'd1100));
    directed_rows.push_back(request_row(8'd0, 32'd1900));
    directed_rows.push_back(request_row(8'd0, 32'd2000));
    directed_rows.push_back(request_row(8'd7, 32'hFFFF_FFFF));
    directed_rows.push_back(request_row(8'd8, 32'd0, 1'b1, rejected(8'd8)));
    directed_rows.push_back(request_row(8'd255, 32'hFFFF_FFFF, 1'b1, rejected(8'd255)));
    directed_rows.push_back(request_row(8'd3, 32'h8000_0000));
    // elapsed time wraps past zero
    directed_rows.push_back(request_row(8'd7, 32'h0000_03E7));
    directed_rows.push_back(register_row(REG_LED_COUNT, 16'h0000));
    directed_rows.push_back(request_row(8'd0, 32'd5000, 1'b1, rejected(8'd0)));
    directed_rows.push_back(register_row(REG_LED_COUNT, 16'hFFFF));
    directed_rows.push_back(request_row(8'd8, 32'd5000, 1'b1, rejected(8'd8)));
    directed_rows.push_back(request_row(8'd7, 32'h0000_0400));
    directed_rows.push_back(register_row(REG_BLINK_FREQUENCY, 16'h0000));
    directed_rows.push_back(request_row(8'd1, 32'd12345, 1'b1, rejected(8'd1)));
    directed_rows.push_back(register_row(REG_BLINK_FREQUENCY, 16'hFFFF));
    directed_rows.push_back(request_row(8'd2, 32'd0));
    directed_rows.push_back(request_row(8'd7, 32'h0000_0400));
    directed_rows.push_back(register_row(REG_BLINK_FREQUENCY, 16'd1));
    directed_rows.push_back(register_row(REG_LED_COUNT, 16'd8));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REGISTER) begin
        drain_results();
        write_register(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        send_request(directed_rows[i].led, directed_rows[i].now, directed_rows[i].typed,
                     directed_rows[i].want);
      end
    end

    clock_ms = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_register(REG_BLINK_FREQUENCY, FREQ_W'(phase_freq[p]));
      // upper data bits are junk for the count register
      write_register(REG_LED_COUNT, {12'($urandom_range(0, 4095)), 4'(phase_count[p])});
      live = (leds_enabled < LED_SLOTS) ? int'(leds_enabled) : LED_SLOTS;
      span = (freq_div == '0) ? 40 : 1000 / int'(freq_div) / 8 + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 10 || live == 0) idx = INDEX_W'($urandom_range(0, 255));
        else idx = INDEX_W'($urandom_range(0, live - 1));
        if ($urandom_range(99) < 3) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, span);
        send_request(idx, clock_ms, 1'b0, '0);
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the input side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && requests_sent >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin : check_results
    pwm_result_t want;
    pwm_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{led_number: led_number, accepted: accepted, led_lit: led_lit,
              level_changed: level_changed, duty_percent: duty_percent};
      if (result_queue.size() == 0) begin
        $display("%0t: result with no request pending: led %0d acc %0b lit %0b chg %0b duty %0d",
                 $time, got.led_number, got.accepted, got.led_lit, got.level_changed,
                 got.duty_percent);
        error_count++;
      end else begin
        want = result_queue.pop_front();
        if (got !== want) begin
          $display("%0t: expected led %0d acc %0b lit %0b chg %0b duty %0d,",
                   $time, want.led_number, want.accepted, want.led_lit, want.level_changed,
                   want.duty_percent,
                   " got led %0d acc %0b lit %0b chg %0b duty %0d",
                   got.led_number, got.accepted, got.led_lit,
                   got.level_changed, got.duty_percent);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
hdl/mlbp_pkg.sv
hdl/multi_led_breathing_pwm_top.sv
bench/testbench.sv
